// ----- design/u8dw_pkg.sv -----
`timescale 1ns / 1ps

package u8dw_pkg;

   // Input item: one byte of UTF-8 text
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   // Result item: one decoded code point
   typedef struct packed {
      logic [20:0] codepoint;
      logic [1:0]  col_width;
      logic        malformed;
      logic        run_last;
   } rsp_type;

   // Work descriptor for one byte: bad_count replacement results,
   // then optionally one good code point
   typedef struct packed {
      logic [2:0]  bad_count;
      logic        has_good;
      logic [20:0] codepoint;
   } desc_type;

   // Queue write from the front end
   typedef struct packed {
      logic     push;
      desc_type desc;
   } q_write_type;

   typedef struct packed {
      logic [20:0] lo;
      logic [20:0] hi;
   } span_type;

   localparam logic [20:0] REPL_CP       = 21'h00FFFD;
   localparam logic [20:0] MAX_CP        = 21'h10FFFF;
   localparam logic [20:0] SURR_LO       = 21'h00D800;
   localparam logic [20:0] SURR_HI       = 21'h00DFFF;
   localparam logic [20:0] MIN_TWO_CP    = 21'h000080;
   localparam logic [20:0] MIN_THREE_CP  = 21'h000800;
   localparam logic [20:0] MIN_FOUR_CP   = 21'h010000;
   localparam logic [20:0] C0_END        = 21'h000020;
   localparam logic [20:0] DEL_CP        = 21'h00007F;
   localparam logic [20:0] C1_END        = 21'h0000A0;

   localparam logic [1:0] WIDTH_ZERO   = 2'd0;
   localparam logic [1:0] WIDTH_NORMAL = 2'd1;
   localparam logic [1:0] WIDTH_WIDE   = 2'd2;

   localparam int ZERO_COUNT = 44;
   localparam int WIDE_COUNT = 21;

   localparam span_type ZERO_SPANS [ZERO_COUNT] = '{
      '{21'h0300, 21'h036F}, '{21'h0483, 21'h0489}, '{21'h0591, 21'h05BD},
      '{21'h05BF, 21'h05BF}, '{21'h05C1, 21'h05C2}, '{21'h05C4, 21'h05C5},
      '{21'h05C7, 21'h05C7}, '{21'h0610, 21'h061A}, '{21'h064B, 21'h065F},
      '{21'h0670, 21'h0670}, '{21'h06D6, 21'h06DC}, '{21'h06DF, 21'h06E4},
      '{21'h06E7, 21'h06E8}, '{21'h06EA, 21'h06ED}, '{21'h0711, 21'h0711},
      '{21'h0730, 21'h074A}, '{21'h07A6, 21'h07B0}, '{21'h07EB, 21'h07F3},
      '{21'h0900, 21'h0902}, '{21'h093A, 21'h093A}, '{21'h093C, 21'h093C},
      '{21'h0941, 21'h0948}, '{21'h094D, 21'h094D}, '{21'h0951, 21'h0957},
      '{21'h0962, 21'h0963}, '{21'h0981, 21'h0981}, '{21'h09BC, 21'h09BC},
      '{21'h09C1, 21'h09C4}, '{21'h09CD, 21'h09CD}, '{21'h0E31, 21'h0E31},
      '{21'h0E34, 21'h0E3A}, '{21'h0E47, 21'h0E4E}, '{21'h0EB1, 21'h0EB1},
      '{21'h0EB4, 21'h0EBC}, '{21'h0EC8, 21'h0ECD}, '{21'h1AB0, 21'h1AFF},
      '{21'h1DC0, 21'h1DFF}, '{21'h200B, 21'h200F}, '{21'h202A, 21'h202E},
      '{21'h2060, 21'h2064}, '{21'h20D0, 21'h20F0}, '{21'hFE00, 21'hFE0F},
      '{21'hFE20, 21'hFE2F}, '{21'hE0100, 21'hE01EF}
   };

   localparam span_type WIDE_SPANS [WIDE_COUNT] = '{
      '{21'h1100, 21'h115F}, '{21'h2329, 21'h232A}, '{21'h2E80, 21'h303E},
      '{21'h3041, 21'h33FF}, '{21'h3400, 21'h4DBF}, '{21'h4E00, 21'h9FFF},
      '{21'hA000, 21'hA4CF}, '{21'hA960, 21'hA97F}, '{21'hAC00, 21'hD7A3},
      '{21'hF900, 21'hFAFF}, '{21'hFE10, 21'hFE19}, '{21'hFE30, 21'hFE6F},
      '{21'hFF00, 21'hFF60}, '{21'hFFE0, 21'hFFE6}, '{21'h1F004, 21'h1F004},
      '{21'h1F0CF, 21'h1F0CF}, '{21'h1F1E6, 21'h1F1FF}, '{21'h1F300, 21'h1F64F},
      '{21'h1F900, 21'h1F9FF}, '{21'h1FA00, 21'h1FAFF}, '{21'h20000, 21'h3FFFD}
   };

   // Terminal column width: parallel range compares against fixed tables
   function automatic logic [1:0] col_width_of(input logic [20:0] cp);
      logic zero_hit;
      logic wide_hit;
      zero_hit = (cp < C0_END) || ((cp >= DEL_CP) && (cp < C1_END));
      wide_hit = 1'b0;
      for (int i = 0; i < ZERO_COUNT; i++) begin
         if ((cp >= ZERO_SPANS[i].lo) && (cp <= ZERO_SPANS[i].hi)) zero_hit = 1'b1;
      end
      for (int i = 0; i < WIDE_COUNT; i++) begin
         if ((cp >= WIDE_SPANS[i].lo) && (cp <= WIDE_SPANS[i].hi)) wide_hit = 1'b1;
      end
      if (zero_hit) return WIDTH_ZERO;
      if (wide_hit) return WIDTH_WIDE;
      return WIDTH_NORMAL;
   endfunction

endpackage

// ----- design/u8dw_front.sv -----
`timescale 1ns / 1ps

module u8dw_front
   import u8dw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  req_type     req_data,
   output q_write_type q_wr
);

   logic [1:0]  held_ff, held_in;
   logic [1:0]  exp_ff, exp_in;
   logic [20:0] part_ff, part_in;

   logic [7:0]  byte_val;
   logic        is_cont;
   logic        lead_ascii, lead_two, lead_three, lead_four, lead_bad;
   logic [1:0]  lead_exp;
   logic [20:0] lead_part;
   logic [20:0] cont_value;
   logic [2:0]  cont_cnt;
   logic        reject;
   logic [2:0]  bad_count;
   logic        has_good;
   logic [20:0] good_cp;

   assign byte_val = req_data.data_byte;
   assign is_cont  = (byte_val[7:6] == 2'b10);

   // Lead byte classification
   assign lead_ascii = ~byte_val[7];
   assign lead_two   = (byte_val[7:5] == 3'b110);
   assign lead_three = (byte_val[7:4] == 4'b1110);
   assign lead_four  = (byte_val[7:3] == 5'b11110);
   assign lead_bad   = ~(lead_ascii | lead_two | lead_three | lead_four);

   always_comb begin
      lead_exp  = 2'd3;
      lead_part = {18'd0, byte_val[2:0]};
      if (lead_two) begin
         lead_exp  = 2'd1;
         lead_part = {16'd0, byte_val[4:0]};
      end else if (lead_three) begin
         lead_exp  = 2'd2;
         lead_part = {17'd0, byte_val[3:0]};
      end
   end

   // Continuation: shift in six value bits
   assign cont_value = {part_ff[14:0], byte_val[5:0]};
   assign cont_cnt   = {1'b0, held_ff} + 3'd1;

   // Range checks on a completed sequence
   always_comb begin
      case (exp_ff)
         2'd1:    reject = (cont_value < MIN_TWO_CP);
         2'd2:    reject = (cont_value < MIN_THREE_CP) ||
                           ((cont_value >= SURR_LO) && (cont_value <= SURR_HI));
         default: reject = (cont_value < MIN_FOUR_CP) || (cont_value > MAX_CP);
      endcase
   end

   // Next decode state and the descriptor for this byte
   always_comb begin
      held_in   = held_ff;
      exp_in    = exp_ff;
      part_in   = part_ff;
      bad_count = 3'd0;
      has_good  = 1'b0;
      good_cp   = cont_value;
      if ((held_ff == 2'd0) || !is_cont) begin
         // broken sequence: one replacement per held byte, then restart
         bad_count = {1'b0, held_ff};
         held_in   = 2'd0;
         exp_in    = 2'd0;
         part_in   = 21'd0;
         if (lead_ascii) begin
            has_good = 1'b1;
            good_cp  = {13'd0, byte_val};
         end else if (lead_bad) begin
            bad_count = bad_count + 3'd1;
         end else begin
            held_in = 2'd1;
            exp_in  = lead_exp;
            part_in = lead_part;
         end
      end else if (held_ff < exp_ff) begin
         held_in = cont_cnt[1:0];
         part_in = cont_value;
      end else begin
         if (reject) begin
            bad_count = cont_cnt;
         end else begin
            has_good = 1'b1;
         end
         held_in = 2'd0;
         exp_in  = 2'd0;
         part_in = 21'd0;
      end
      // end of string flushes a pending sequence
      if (req_data.end_of_string && (held_in != 2'd0)) begin
         bad_count = bad_count + {1'b0, held_in};
         held_in   = 2'd0;
         exp_in    = 2'd0;
         part_in   = 21'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         exp_ff  <= 2'd0;
         part_ff <= 21'd0;
      end else if (req_fire) begin
         held_ff <= held_in;
         exp_ff  <= exp_in;
         part_ff <= part_in;
      end
   end

   assign q_wr.push           = req_fire && (has_good || (bad_count != 3'd0));
   assign q_wr.desc.bad_count = bad_count;
   assign q_wr.desc.has_good  = has_good;
   assign q_wr.desc.codepoint = good_cp;

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff != 2'd0) |-> ((exp_ff != 2'd0) && (held_ff <= exp_ff)))
      else $error("pending byte count exceeds expected length");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.end_of_string) |=> (held_ff == 2'd0))
      else $error("sequence still pending after end of string");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> (({1'b0, q_wr.desc.bad_count} + {3'd0, q_wr.desc.has_good}) <= 4'd4))
      else $error("more than four results for one byte");

endmodule

// ----- design/u8dw_queue.sv -----
`timescale 1ns / 1ps

module u8dw_queue
   import u8dw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  q_write_type q_wr,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output desc_type    head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = q_wr.push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Descriptor storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wr.desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !full)
      else $error("descriptor pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ----- design/u8dw_back.sv -----
`timescale 1ns / 1ps

module u8dw_back
   import u8dw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] total;
   logic       is_last;
   logic       load;
   logic [1:0] good_width;

   // Results for the head descriptor, one per cycle while rsp_ready takes them
   assign total      = head.bad_count + {2'd0, head.has_good};
   assign is_last    = (({1'b0, idx_ff} + 3'd1) == total);
   assign load       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = load && is_last;
   assign good_width = col_width_of(head.codepoint);

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
         if ({1'b0, idx_ff} < head.bad_count) begin
            rsp_data_in.codepoint = REPL_CP;
            rsp_data_in.col_width = WIDTH_NORMAL;
            rsp_data_in.malformed = 1'b1;
         end else begin
            rsp_data_in.codepoint = head.codepoint;
            rsp_data_in.col_width = good_width;
            rsp_data_in.malformed = 1'b0;
         end
         rsp_data_in.run_last = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < total))
      else $error("result index beyond descriptor length");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == 2'd0))
      else $error("result index not cleared with empty queue");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed before transfer");

endmodule

// ----- design/utf8_decode_with_width_unit.sv -----
// Path: a byte's results are registered in the descriptor queue, then in the output register.
// Throughput: one byte per cycle while the queue has room and each byte gives at most one result;
// the output register issues one result per cycle unless stalled, so multi-result bytes hold it.
// The descriptor queue (QUEUE_DEPTH entries) absorbs bursts of multi-result bytes.
// Reset: synchronous, clears decode state, queue pointers and output valid at once.
`timescale 1ns / 1ps

module utf8_decode_with_width_unit
   import u8dw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_write_type q_wr;
   logic        q_full;
   logic        head_valid;
   desc_type    head;
   logic        pop;
   logic        req_fire;

   // Input transfer whenever the queue has room
   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   u8dw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .q_wr     (q_wr)
   );

   u8dw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_wr       (q_wr),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   u8dw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
